FILE: design/sss_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and decode functions of the seven-segment scan driver.
// Depends on nothing; every other design file uses it.
package sss_pkg;

	localparam int NumDigits   = 4;
	localparam int CodeW       = 4;
	localparam int PosW        = 2;
	localparam int HoldW       = 8;
	localparam int NumberW     = 16;
	localparam int SegW        = 8;
	localparam int ValueW      = 14;
	localparam int PartW       = 7;
	localparam int ApbDataW    = 32;
	localparam int ApbAddrW    = 3;

	localparam logic [CodeW-1:0]   BlankCode   = 4'd10;
	localparam logic [ValueW-1:0]  MaxValue    = 14'd9999;
	localparam logic [PartW-1:0]   TensLimit   = 7'd10;
	localparam logic [HoldW-1:0]   HoldReset   = 8'd3;
	localparam logic [HoldW-1:0]   HoldMax     = 8'hFF;
	localparam logic [NumDigits-1:0] PointReset = 4'b1000;
	localparam logic [NumDigits-1:0] PointLoad  = 4'b0100;

	// Register indexes, taken from paddr above the byte offset.
	typedef enum logic {
		REG_HOLD_TICKS = 1'b0
	} reg_idx_t;

	typedef logic [CodeW-1:0] code_t;

	typedef struct packed {
		logic                        cmd;
		logic [NumDigits-1:0][CodeW-1:0] codes;
	} item_t;

	localparam logic CmdSet  = 1'b0;
	localparam logic CmdTick = 1'b1;

	// Quotient by ten for values up to 99, by reciprocal multiplication.
	function automatic logic [CodeW-1:0] div10(input logic [PartW-1:0] x);
		logic [13:0] p;
		p = {7'b0, x} * 14'd103;
		return p[13:10];
	endfunction

	function automatic logic [CodeW-1:0] mod10(input logic [PartW-1:0] x);
		logic [PartW-1:0] q;
		logic [PartW-1:0] t;
		q = {3'b0, div10(x)};
		t = x - ((q << 3) + (q << 1));
		return t[CodeW-1:0];
	endfunction

	// Active-high segments A..G for one digit code; codes above nine are dark.
	function automatic logic [6:0] seg_decode(input code_t code);
		logic [6:0] s;
		case (code)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

FILE: design/sss_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command items and display results.
// Depends on sss_pkg for field widths.
interface sss_req_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [sss_pkg::NumberW-1:0]   number;
	modport source (output valid, output cmd, output number, input ready);
	modport sink (input valid, input cmd, input number, output ready);
endinterface

interface sss_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [sss_pkg::SegW-1:0]      seg_drive_n;
	logic [sss_pkg::NumDigits-1:0] digit_select;
	modport source (output valid, output seg_drive_n, output digit_select, input ready);
	modport sink (input valid, input seg_drive_n, input digit_select, output ready);
endinterface

FILE: design/four_digit_sevenseg_scan_driver_unit.sv
`timescale 1ns / 1ps
// Four-digit seven-segment scan driver: a command passes the input, split and result
// registers to its result transfer; one command is taken every cycle unless the result
// channel stalls, as set by the three-stage split/update pipeline with per-stage stall.
// Asynchronous active-low reset empties the pipeline, blanks the two left digits,
// shows zero on the right two with the point on the rightmost, and sets hold_ticks to 3.
module four_digit_sevenseg_scan_driver_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	sss_req_if.sink                      req,
	sss_rsp_if.source                    rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sss_pkg::ApbAddrW-1:0] paddr,
	input  logic [sss_pkg::ApbDataW-1:0] pwdata,
	output logic [sss_pkg::ApbDataW-1:0] prdata,
	output logic                         pready
);
	import sss_pkg::*;

	logic             take;
	logic             valid_s2;
	item_t            item;
	logic [HoldW-1:0] hold_ticks;

	sss_apb u_apb (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.hold_ticks (hold_ticks)
	);

	sss_split u_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.take     (take),
		.valid_s2 (valid_s2),
		.item     (item)
	);

	sss_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s2   (valid_s2),
		.item       (item),
		.hold_ticks (hold_ticks),
		.take       (take),
		.rsp        (rsp)
	);
endmodule

FILE: design/sss_apb.sv
`timescale 1ns / 1ps
// APB register block holding the hold_ticks scan period.
// Depends on sss_pkg.
module sss_apb (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sss_pkg::ApbAddrW-1:0] paddr,
	input  logic [sss_pkg::ApbDataW-1:0] pwdata,
	output logic [sss_pkg::ApbDataW-1:0] prdata,
	output logic                         pready,
	output logic [sss_pkg::HoldW-1:0]    hold_ticks
);
	import sss_pkg::*;

	logic [HoldW-1:0] hold_ticks_q;
	reg_idx_t         idx;

	assign idx    = reg_idx_t'(paddr[ApbAddrW-1]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= HoldReset;
		end else if (psel && penable && pwrite && pready && idx == REG_HOLD_TICKS) begin
			hold_ticks_q <= pwdata[HoldW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_HOLD_TICKS: prdata = {{(ApbDataW-HoldW){1'b0}}, hold_ticks_q};
			default:        prdata = '0;
		endcase
	end

	assign hold_ticks = hold_ticks_q;
endmodule

FILE: design/sss_split.sv
`timescale 1ns / 1ps
// Input register and decimal split: clamps the number and breaks it into digit codes.
// Depends on sss_pkg and sss_if.
module sss_split (
	input  logic          clk,
	input  logic          arst_n,
	sss_req_if.sink       req,
	input  logic          take,
	output logic          valid_s2,
	output sss_pkg::item_t item
);
	import sss_pkg::*;

	logic              valid_s1;
	logic              cmd_s1;
	logic [ValueW-1:0] value_s1;
	logic              cmd_s2;
	logic [PartW-1:0]  hund_s2;
	logic [PartW-1:0]  rest_s2;
	logic              en_s1;
	logic              en_s2;
	logic [ValueW-1:0] clamped;
	logic [26:0]       prod;
	logic [PartW-1:0]  hund;
	logic [ValueW-1:0] rest;

	assign en_s2     = !valid_s2 || take;
	assign en_s1     = !valid_s1 || en_s2;
	assign req.ready = en_s1;

	always_comb begin
		if (req.number[NumberW-1]) begin
			clamped = '0;
		end else if (req.number > {2'b0, MaxValue}) begin
			clamped = MaxValue;
		end else begin
			clamped = req.number[ValueW-1:0];
		end
	end

	// Quotient by one hundred, exact for every value up to 9999.
	assign prod = {13'b0, value_s1} * 27'd5243;
	assign hund = prod[25:19];
	assign rest = value_s1 - ({7'b0, hund} * 14'd100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= req.valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && req.valid) begin
			cmd_s1   <= req.cmd;
			value_s1 <= clamped;
		end
		if (en_s2 && valid_s1) begin
			cmd_s2  <= cmd_s1;
			hund_s2 <= hund;
			rest_s2 <= rest[PartW-1:0];
		end
	end

	always_comb begin
		item.cmd      = cmd_s2;
		item.codes[0] = (hund_s2 < TensLimit) ? BlankCode : div10(hund_s2);
		item.codes[1] = mod10(hund_s2);
		item.codes[2] = div10(rest_s2);
		item.codes[3] = mod10(rest_s2);
	end
endmodule

FILE: design/sss_scan.sv
`timescale 1ns / 1ps
// Display state, scan timer, segment decode and the result register.
// Depends on sss_pkg and sss_if.
module sss_scan (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s2,
	input  sss_pkg::item_t            item,
	input  logic [sss_pkg::HoldW-1:0] hold_ticks,
	output logic                      take,
	sss_rsp_if.source                 rsp
);
	import sss_pkg::*;

	logic [NumDigits-1:0][CodeW-1:0] codes_q;
	logic [NumDigits-1:0][CodeW-1:0] codes_d;
	logic [NumDigits-1:0]            points_q;
	logic [NumDigits-1:0]            points_d;
	logic [PosW-1:0]                 pos_q;
	logic [PosW-1:0]                 pos_d;
	logic [HoldW-1:0]                cnt_q;
	logic [HoldW-1:0]                cnt_d;
	logic [HoldW-1:0]                limit;
	logic [HoldW:0]                  cnt_inc;
	logic                            out_valid_q;
	logic [SegW-1:0]                 seg_q;
	logic [NumDigits-1:0]            sel_q;
	logic                            fire;
	logic [6:0]                      lit;

	assign take = !out_valid_q || rsp.ready;
	assign fire = take && valid_s2;

	assign limit   = (hold_ticks == '0) ? {{(HoldW-1){1'b0}}, 1'b1} : hold_ticks;
	assign cnt_inc = {1'b0, cnt_q} + {{HoldW{1'b0}}, 1'b1};

	always_comb begin
		codes_d  = codes_q;
		points_d = points_q;
		pos_d    = pos_q;
		cnt_d    = cnt_q;
		if (item.cmd == CmdSet) begin
			codes_d  = item.codes;
			points_d = PointLoad;
		end else if (cnt_q == HoldMax || cnt_inc >= {1'b0, limit}) begin
			cnt_d = '0;
			pos_d = pos_q + {{(PosW-1){1'b0}}, 1'b1};
		end else begin
			cnt_d = cnt_inc[HoldW-1:0];
		end
	end

	assign lit = seg_decode(codes_d[pos_d]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q     <= {4'd0, 4'd0, BlankCode, BlankCode};
			points_q    <= PointReset;
			pos_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				codes_q  <= codes_d;
				points_q <= points_d;
				pos_q    <= pos_d;
				cnt_q    <= cnt_d;
			end
			if (take) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			seg_q <= ~{points_d[pos_d], lit};
			sel_q <= {{(NumDigits-1){1'b0}}, 1'b1} << pos_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.seg_drive_n  = seg_q;
	assign rsp.digit_select = sel_q;
endmodule

FILE: design/sss_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the scan driver's result channel.
// Depends on sss_pkg; bound to four_digit_sevenseg_scan_driver_unit below.
module sss_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [sss_pkg::SegW-1:0]      seg_drive_n,
	input logic [sss_pkg::NumDigits-1:0] digit_select
);
	import sss_pkg::*;

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot(digit_select))
		else $error("digit enable is not one-hot");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(seg_drive_n)
			&& $stable(digit_select))
		else $error("stalled result changed");

	// The point is only ever set on the two right-hand digits.
	a_point_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !seg_drive_n[SegW-1] |-> digit_select[2] || digit_select[3])
		else $error("decimal point on a left digit");

	// The leftmost digit is blank below 1000, so it never shows a zero.
	a_no_left_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && digit_select[0] |-> seg_drive_n[6:0] != ~7'h3F)
		else $error("leftmost digit shows zero");
endmodule

bind four_digit_sevenseg_scan_driver_unit sss_checker u_sss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.seg_drive_n  (rsp.seg_drive_n),
	.digit_select (rsp.digit_select)
);
